@@ rtl/core/pct_pkg.sv @@
// ----------------------------------------------------------------------------
// pct_pkg
// Types and constants shared by the piece chunk tracker modules.
// ----------------------------------------------------------------------------
package pct_pkg;

    // Field widths fixed by the interface
    localparam int PIECE_W   = 10;
    localparam int CHUNK_W   = 4;
    localparam int NPIECES_W = 11;
    localparam int NCHUNKS_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    // Bitmap word width, tied to the chunk index width
    localparam int MAX_CHUNKS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIECES        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_PER_PIECE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_PIECE_CHUNKS = 2'd2;

    // Register reset values
    localparam logic [NPIECES_W-1:0] NUM_PIECES_RST = 11'd1;
    localparam logic [NCHUNKS_W-1:0] NCHUNKS_RST    = 5'd16;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_ARRIVE  = 2'd0,
        MODE_SET_REQ = 2'd1,
        MODE_CLR_REQ = 2'd2,
        MODE_FIND    = 2'd3
    } mode_t;

    // Request payload
    typedef struct packed {
        mode_t              mode;
        logic [PIECE_W-1:0] piece_index;
        logic [CHUNK_W-1:0] chunk_index;
    } req_t;

    // Response payload
    typedef struct packed {
        logic               status;
        logic               piece_complete;
        logic               missing_found;
        logic [CHUNK_W-1:0] missing_chunk;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } pct_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // write zero at the sweep address, advance sweep
        logic accept;     // capture request, read both piece words
        logic finish;     // write back updated words, load response register
    } pct_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last; // sweep address is at the last entry
    } pct_sts_t;

endpackage

@@ rtl/core/pct_ctrl.sv @@
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: clearing sweep after reset, then one request at a time, held
// until the response register is free; the response valid flag is kept here.
// ----------------------------------------------------------------------------
module pct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pct_pkg::pct_sts_t sts,
    output pct_pkg::pct_cmd_t cmd
);
    import pct_pkg::*;

    pct_state_t state_reg;
    pct_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and response flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.accept   = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the response register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Response valid: set on finish, dropped once taken
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request taken during clearing sweep");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed next cycle");

    a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("response register overwritten while held");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("response valid without a finished request");

endmodule

@@ rtl/core/pct_dpath.sv @@
// ----------------------------------------------------------------------------
// pct_dpath
// Configuration registers, the received and requested bitmap memories,
// request register, update logic and response register.
// ----------------------------------------------------------------------------
module pct_dpath #(
    parameter int MAX_PIECES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pct_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pct_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  pct_pkg::req_t                       in_data,
    output pct_pkg::rsp_t                       out_data,
    input  pct_pkg::pct_cmd_t                   cmd,
    output pct_pkg::pct_sts_t                   sts
);
    import pct_pkg::*;

    localparam int AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int NW = $clog2(MAX_CHUNKS + 1);

    logic [NPIECES_W-1:0] num_pieces_reg;
    logic [NCHUNKS_W-1:0] chunks_per_piece_reg;
    logic [NCHUNKS_W-1:0] last_piece_chunks_reg;

    logic [MAX_CHUNKS-1:0] recv_mem [MAX_PIECES];
    logic [MAX_CHUNKS-1:0] reqd_mem [MAX_PIECES];
    logic [MAX_CHUNKS-1:0] recv_rd_reg;
    logic [MAX_CHUNKS-1:0] reqd_rd_reg;

    req_t    req_reg;
    rsp_t    rsp_reg;
    rsp_t    rsp_next;
    logic [AW-1:0] clr_cnt_reg;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         req_addr;
    logic [AW-1:0]         wr_addr;
    logic                  recv_we;
    logic                  reqd_we;
    logic [MAX_CHUNKS-1:0] recv_wdata;
    logic [MAX_CHUNKS-1:0] reqd_wdata;

    logic                  piece_ok;
    logic                  is_last;
    logic [NCHUNKS_W-1:0]  n_raw;
    logic [NW-1:0]         n_chunks;
    logic                  chunk_ok;
    logic [MAX_CHUNKS-1:0] mask;
    logic [MAX_CHUNKS-1:0] bit_sel;
    logic [MAX_CHUNKS-1:0] recv_new;
    logic [MAX_CHUNKS-1:0] reqd_new;
    logic [MAX_CHUNKS-1:0] free_bits;
    logic [CHUNK_W-1:0]    free_idx;
    logic                  recv_upd;
    logic                  reqd_upd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pieces_reg        <= NUM_PIECES_RST;
            chunks_per_piece_reg  <= NCHUNKS_RST;
            last_piece_chunks_reg <= NCHUNKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_PIECES:        num_pieces_reg        <= cfg_data;
                CFG_CHUNKS_PER_PIECE:  chunks_per_piece_reg  <= cfg_data[NCHUNKS_W-1:0];
                CFG_LAST_PIECE_CHUNKS: last_piece_chunks_reg <= cfg_data[NCHUNKS_W-1:0];
                default:               ;
            endcase
        end
    end

    // Clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clear_last = (clr_cnt_reg == AW'(MAX_PIECES - 1));

    // Request register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= in_data;
        end
    end

    assign rd_addr  = AW'(in_data.piece_index);
    assign req_addr = AW'(req_reg.piece_index);

    // Bitmap memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (recv_we)
        begin
            recv_mem[wr_addr] <= recv_wdata;
        end
        if (cmd.accept)
        begin
            recv_rd_reg <= recv_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (reqd_we)
        begin
            reqd_mem[wr_addr] <= reqd_wdata;
        end
        if (cmd.accept)
        begin
            reqd_rd_reg <= reqd_mem[rd_addr];
        end
    end

    // Piece range and chunk count
    always_comb
    begin
        piece_ok = (NPIECES_W'(req_reg.piece_index) < num_pieces_reg)
                && (32'(req_reg.piece_index) < MAX_PIECES);
        is_last  = (NPIECES_W'(req_reg.piece_index) + NPIECES_W'(1)) == num_pieces_reg;
        n_raw    = is_last ? last_piece_chunks_reg : chunks_per_piece_reg;
        if (32'(n_raw) > MAX_CHUNKS)
        begin
            n_chunks = NW'(MAX_CHUNKS);
        end
        else
        begin
            n_chunks = NW'(n_raw);
        end
        chunk_ok = 32'(req_reg.chunk_index) < 32'(n_chunks);
    end

    // Per-chunk mask and selected bit
    always_comb
    begin
        for (int j = 0; j < MAX_CHUNKS; j++)
        begin
            mask[j]    = 32'(n_chunks) > j;
            bit_sel[j] = 32'(req_reg.chunk_index) == j;
        end
    end

    // Updated words and lowest free chunk
    always_comb
    begin
        recv_new  = recv_rd_reg | bit_sel;
        reqd_new  = (req_reg.mode == MODE_SET_REQ) ? (reqd_rd_reg | bit_sel)
                                                   : (reqd_rd_reg & ~bit_sel);
        free_bits = ~(recv_rd_reg | reqd_rd_reg) & mask;
        free_idx  = '0;
        for (int j = MAX_CHUNKS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                free_idx = CHUNK_W'(j);
            end
        end
    end

    // Response
    always_comb
    begin
        rsp_next = '0;
        recv_upd = 1'b0;
        reqd_upd = 1'b0;
        if (!piece_ok)
        begin
            rsp_next.status = 1'b1;
        end
        else if (req_reg.mode == MODE_FIND)
        begin
            rsp_next.missing_found = |free_bits;
            rsp_next.missing_chunk = free_idx;
        end
        else if (!chunk_ok)
        begin
            rsp_next.status = 1'b1;
        end
        else if (req_reg.mode == MODE_ARRIVE)
        begin
            recv_upd = 1'b1;
            rsp_next.piece_complete = ((recv_new & mask) == mask);
        end
        else
        begin
            reqd_upd = 1'b1;
        end
    end

    // Write port select: sweep or write-back
    assign wr_addr    = cmd.clear_wr ? clr_cnt_reg : req_addr;
    assign recv_we    = cmd.clear_wr || (cmd.finish && recv_upd);
    assign reqd_we    = cmd.clear_wr || (cmd.finish && reqd_upd);
    assign recv_wdata = cmd.clear_wr ? '0 : recv_new;
    assign reqd_wdata = cmd.clear_wr ? '0 : reqd_new;

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_data = rsp_reg;

endmodule

@@ rtl/core/piece_chunk_tracker.sv @@
// ----------------------------------------------------------------------------
// piece_chunk_tracker
// Per-piece bookkeeping of received and requested chunks.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with in_data (mode, piece, chunk);
// responses leave on out_valid/out_ready with out_data (status, piece
// complete, missing found, missing chunk). One response per request.
// Configuration registers (piece count, chunks per piece, chunks in the
// last piece) are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, the block itself does not enforce it.
// A request passes an accept state, which reads both bitmap words of the
// piece from memory, then an execute state, which computes the result,
// writes the words back and loads the response register once no held
// response blocks it; this read-modify-write takes one request at a time.
// After reset both bitmap memories are swept to zero, one entry per cycle,
// over all MAX_PIECES entries; in_ready stays low meanwhile, configuration
// writes are taken as usual. A stalled response is held in its register;
// the next request may be accepted, and its result waits until it is taken.
// ----------------------------------------------------------------------------
module piece_chunk_tracker #(
    parameter int MAX_PIECES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pct_pkg::req_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pct_pkg::rsp_t                   out_data
);
    import pct_pkg::*;

    pct_cmd_t cmd;
    pct_sts_t sts;

    // Sequencer
    pct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath and bitmap storage
    pct_dpath #(
        .MAX_PIECES (MAX_PIECES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ dv/piece_chunk_tracker_test.sv @@
// ----------------------------------------------------------------------------
// piece_chunk_tracker_test
// Self-checking bench for the piece chunk tracker. A short directed table
// walks reset state, range errors, oversized and zero chunk counts and piece
// completion; then random phases, each under its own register setting, mix
// fill sequences on live pieces with noise. Every response is checked field
// by field against a local bitmap model or a fixed expectation.
// ----------------------------------------------------------------------------
module piece_chunk_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int LONG_HOLD   = 200;
    localparam int MAX_PRINTS  = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    req_t                  in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    rsp_t                  out_data;

    // fixed expectation riding along with the request that carries it
    logic tag_fixed_en = 1'b0;
    rsp_t tag_fixed = '0;

    // local copy of the block state
    logic [15:0]           rcv_map [1024];
    logic [15:0]           req_map [1024];
    logic [NPIECES_W-1:0]  np_reg;
    logic [NCHUNKS_W-1:0]  cpp_reg;
    logic [NCHUNKS_W-1:0]  lpc_reg;

    rsp_t pending_rsp_q [$];
    int   n_req_taken = 0;
    int   n_rsp_seen = 0;
    int   n_errors = 0;

    // traffic knobs
    int   tx_gap_pct = 0;
    int   rx_stall_pct = 0;
    bit   long_hold_req = 1'b0;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        req_t                  req;
        bit                    has_fixed;
        rsp_t                  fixed;
    } dir_row_t;

    dir_row_t dir_rows [$];

    piece_chunk_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Chunk count of a piece, clamped to the bitmap width
    function automatic int piece_chunks(input logic [PIECE_W-1:0] p);
        int n;
        n = ({1'b0, p} + 11'd1 == np_reg) ? int'(lpc_reg) : int'(cpp_reg);
        if (n > 16)
            n = 16;
        return n;
    endfunction

    // Apply one request to the local bitmaps and return its response
    function automatic rsp_t track_op(input req_t r);
        rsp_t        rs;
        int          n;
        logic [16:0] wide;
        logic [15:0] mask;
        logic [15:0] free_bits;
        logic [15:0] bit_sel;
        rs = '0;
        if ({1'b0, r.piece_index} >= np_reg)
        begin
            rs.status = 1'b1;
            return rs;
        end
        n = piece_chunks(r.piece_index);
        wide = (17'd1 << n) - 17'd1;
        mask = wide[15:0];
        if (r.mode == MODE_FIND)
        begin
            free_bits = ~(rcv_map[r.piece_index] | req_map[r.piece_index]) & mask;
            for (int j = 15; j >= 0; j--)
            begin
                if (free_bits[j])
                begin
                    rs.missing_found = 1'b1;
                    rs.missing_chunk = CHUNK_W'(j);
                end
            end
            return rs;
        end
        if (int'(r.chunk_index) >= n)
        begin
            rs.status = 1'b1;
            return rs;
        end
        bit_sel = 16'd1 << r.chunk_index;
        case (r.mode)
            MODE_ARRIVE:
            begin
                rcv_map[r.piece_index] = rcv_map[r.piece_index] | bit_sel;
                rs.piece_complete = ((rcv_map[r.piece_index] & mask) == mask);
            end
            MODE_SET_REQ: req_map[r.piece_index] = req_map[r.piece_index] | bit_sel;
            default:      req_map[r.piece_index] = req_map[r.piece_index] & ~bit_sel;
        endcase
        return rs;
    endfunction

    function automatic rsp_t mk_rsp(input bit st, input bit pc, input bit mf, input int mc);
        rsp_t rs;
        rs.status = st;
        rs.piece_complete = pc;
        rs.missing_found = mf;
        rs.missing_chunk = CHUNK_W'(mc);
        return rs;
    endfunction

    function automatic req_t mk_req(input mode_t m, input int p, input int c);
        req_t r;
        r.mode = m;
        r.piece_index = PIECE_W'(p);
        r.chunk_index = CHUNK_W'(c);
        return r;
    endfunction

    task automatic add_op(input mode_t m, input int p, input int c,
                          input bit fx, input rsp_t f);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.req = mk_req(m, p, c);
        row.has_fixed = fx;
        row.fixed = f;
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        dir_row_t row;
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = CFG_DATA_W'(val);
        row.req = '0;
        row.has_fixed = 1'b0;
        row.fixed = '0;
        dir_rows = {dir_rows, row};
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("%0t mismatch %s: want %0d got %0d", $realtime, what, want, got);
    endtask

    // Register write; cfg_we drops again before return, so it never toggles twice in a step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_NUM_PIECES:        np_reg = NPIECES_W'(val);
            CFG_CHUNKS_PER_PIECE:  cpp_reg = NCHUNKS_W'(val);
            CFG_LAST_PIECE_CHUNKS: lpc_reg = NCHUNKS_W'(val);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one request and hold it until taken, then maybe idle a while
    task automatic send_req(input req_t r, input bit fx, input rsp_t f);
        in_valid <= 1'b1;
        in_data <= r;
        tag_fixed_en <= fx;
        tag_fixed <= f;
        do
            @(posedge clk);
        while (!in_ready);
        if ($urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding response
    task automatic drain_all();
        in_valid <= 1'b0;
        tag_fixed_en <= 1'b0;
        @(posedge clk);
        while (n_rsp_seen != n_req_taken)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_noise();
        send_req(mk_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                        $urandom_range(0, 15)), 1'b0, '0);
    endtask

    // Walk one live piece towards completion in random chunk order
    task automatic fill_piece(output int cnt);
        int lim;
        int p;
        int n;
        int k;
        int tmp;
        int order [16];
        cnt = 0;
        lim = (np_reg > 11'd1024) ? 1023 : int'(np_reg) - 1;
        case ($urandom_range(0, 3))
            0:       p = lim;
            1, 2:    p = $urandom_range(0, (lim < 7) ? lim : 7);
            default: p = $urandom_range(0, lim);
        endcase
        n = piece_chunks(PIECE_W'(p));
        for (int i = 0; i < 16; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        send_req(mk_req(MODE_FIND, p, $urandom_range(0, 15)), 1'b0, '0);
        cnt++;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                send_req(mk_req(MODE_FIND, p, $urandom_range(0, 15)), 1'b0, '0);
                cnt++;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                send_req(mk_req(MODE_SET_REQ, p, order[i]), 1'b0, '0);
                cnt++;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                send_req(mk_req(MODE_ARRIVE, p, order[i]), 1'b0, '0);
                cnt++;
            end
            if ($urandom_range(0, 9) < 4)
            begin
                send_req(mk_req(MODE_CLR_REQ, p, order[$urandom_range(0, n - 1)]),
                         1'b0, '0);
                cnt++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_noise();
                cnt++;
            end
        end
    endtask

    // Predict on every accepted request
    always @(posedge clk)
    begin
        rsp_t pred;
        if (rst_n && in_valid && in_ready)
        begin
            pred = track_op(in_data);
            if (tag_fixed_en)
                pred = tag_fixed;
            pending_rsp_q = {pending_rsp_q, pred};
            n_req_taken++;
        end
    end

    // Check every accepted response against the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_rsp_seen++;
            if (pending_rsp_q.size() == 0)
                flag_mismatch("response with nothing pending", 0, 1);
            else
            begin
                want = pending_rsp_q.pop_front();
                if (out_data.status !== want.status)
                    flag_mismatch("status", int'(want.status), int'(out_data.status));
                if (out_data.piece_complete !== want.piece_complete)
                    flag_mismatch("piece_complete", int'(want.piece_complete),
                                  int'(out_data.piece_complete));
                if (out_data.missing_found !== want.missing_found)
                    flag_mismatch("missing_found", int'(want.missing_found),
                                  int'(out_data.missing_found));
                if (out_data.missing_chunk !== want.missing_chunk)
                    flag_mismatch("missing_chunk", int'(want.missing_chunk),
                                  int'(out_data.missing_chunk));
            end
        end
    end

    // Response side: random stall bursts, one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        dir_row_t row;
        int np;
        int cpp;
        int lpc;
        int sent;
        int got;
        bit paused;

        for (int i = 0; i < 1024; i++)
        begin
            rcv_map[i] = '0;
            req_map[i] = '0;
        end
        np_reg = NUM_PIECES_RST;
        cpp_reg = NCHUNKS_RST;
        lpc_reg = NCHUNKS_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; reset setting is one piece of sixteen chunks
        add_op(MODE_FIND,    0,    0,  1'b1, mk_rsp(1'b0, 1'b0, 1'b1, 0));
        add_op(MODE_ARRIVE,  1,    0,  1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        add_op(MODE_SET_REQ, 1023, 15, 1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        add_op(MODE_SET_REQ, 0,    0,  1'b1, mk_rsp(1'b0, 1'b0, 1'b0, 0));
        add_op(MODE_FIND,    0,    15, 1'b0, '0);
        add_op(MODE_ARRIVE,  0,    15, 1'b0, '0);
        add_op(MODE_CLR_REQ, 0,    0,  1'b1, mk_rsp(1'b0, 1'b0, 1'b0, 0));
        add_op(MODE_CLR_REQ, 0,    0,  1'b1, mk_rsp(1'b0, 1'b0, 1'b0, 0));
        add_op(MODE_ARRIVE,  0,    15, 1'b0, '0);
        // three pieces of two chunks, last one oversized
        add_cfg(CFG_NUM_PIECES, 3);
        add_cfg(CFG_CHUNKS_PER_PIECE, 2);
        add_cfg(CFG_LAST_PIECE_CHUNKS, 20);
        add_cfg(CFG_UNUSED, 2047);
        add_op(MODE_ARRIVE,  0,    2,  1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        add_op(MODE_ARRIVE,  0,    1,  1'b0, '0);
        add_op(MODE_ARRIVE,  0,    0,  1'b0, '0);
        add_op(MODE_FIND,    0,    0,  1'b0, '0);
        add_op(MODE_ARRIVE,  2,    15, 1'b0, '0);
        add_op(MODE_FIND,    2,    15, 1'b0, '0);
        add_op(MODE_ARRIVE,  3,    0,  1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        // zero chunks per piece rejects every chunk
        add_cfg(CFG_CHUNKS_PER_PIECE, 0);
        add_op(MODE_SET_REQ, 1,    0,  1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        add_op(MODE_FIND,    1,    0,  1'b0, '0);
        // zero pieces rejects every piece
        add_cfg(CFG_NUM_PIECES, 0);
        add_op(MODE_FIND,    0,    0,  1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        // full table, one-chunk last piece
        add_cfg(CFG_NUM_PIECES, 1024);
        add_cfg(CFG_CHUNKS_PER_PIECE, 16);
        add_cfg(CFG_LAST_PIECE_CHUNKS, 1);
        add_op(MODE_ARRIVE,  1023, 1,  1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 0));
        add_op(MODE_ARRIVE,  1023, 0,  1'b0, '0);

        tx_gap_pct = 20;
        rx_stall_pct = 20;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                drain_all();
                write_reg(row.cfg_idx, int'(row.cfg_val));
            end
            else
                send_req(row.req, row.has_fixed, row.fixed);
        end

        // Random phases, one register setting each
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_all();
            case (ph)
                0: begin np = 1024; cpp = 16; lpc = 16; end
                1: begin np = 2;    cpp = 16; lpc = 16; end
                2: begin np = 2047; cpp = 1;  lpc = 1;  end
                3: begin np = 4;    cpp = 5;  lpc = 16; end
                4: begin np = 0;    cpp = 16; lpc = 16; end
                5: begin np = 1;    cpp = 31; lpc = 0;  end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       np = $urandom_range(1, 8);
                        1:       np = $urandom_range(1, 1024);
                        2:       np = 1024;
                        default: np = $urandom_range(1025, 2047);
                    endcase
                    cpp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16);
                    lpc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16);
                end
            endcase
            write_reg(CFG_NUM_PIECES, np);
            write_reg(CFG_CHUNKS_PER_PIECE, cpp);
            write_reg(CFG_LAST_PIECE_CHUNKS, lpc);

            // last phases run back to back with no idling
            if (ph >= N_PHASES - 2)
            begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       tx_gap_pct = 0;
                    1:       tx_gap_pct = 5;
                    2:       tx_gap_pct = 25;
                    default: tx_gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0:       rx_stall_pct = 0;
                    1:       rx_stall_pct = 5;
                    2:       rx_stall_pct = 25;
                    default: rx_stall_pct = 50;
                endcase
            end
            // receiver holds off while requests keep coming
            if (ph == 1)
            begin
                tx_gap_pct = 0;
                long_hold_req = 1'b1;
            end

            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                // sender pause until the pipe is empty
                if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    drain_all();
                    paused = 1'b1;
                end
                if (np != 0 && $urandom_range(0, 99) < 70)
                begin
                    fill_piece(got);
                    sent += got;
                end
                else
                begin
                    send_noise();
                    sent++;
                end
            end
        end

        drain_all();
        repeat (10) @(posedge clk);
        if (pending_rsp_q.size() != 0)
            flag_mismatch("responses never delivered", pending_rsp_q.size(), 0);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
